### hdl/msr_pkg.sv
// Shared types, constants and helpers for the motor speed slew ramp.
// No dependencies; imported by every module of the block.
package msr_pkg;

  // Fixed point of the ramp accumulators and increments
  localparam int FRAC_BITS = 16;
  localparam int SPD_W     = 8;
  localparam int ACC_W     = SPD_W + FRAC_BITS;
  localparam int DIVD_W    = SPD_W + FRAC_BITS;
  localparam int QUOT_W    = FRAC_BITS + 1;
  localparam int INC_W     = QUOT_W + 1;
  localparam int DCNT_W    = $clog2(DIVD_W + 1);

  // Ramp bookkeeping
  localparam int TOT_W     = 12;
  localparam int SLEW_W    = 4;
  localparam int MAXS_W    = 7;
  localparam int TMO_W     = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [MAXS_W-1:0] MAX_SPEED_RST = 7'd127;
  localparam logic [SLEW_W-1:0] SLEW_RATE_RST = 4'd1;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 16'd1000;

  // Bus voltage: (raw*100 + 14730) / 154, via reciprocal multiply
  localparam int RAW_W       = 8;
  localparam int VNUM_W      = 16;
  localparam int VOLT_SCALE  = 100;
  localparam int VOLT_OFFSET = 14730;
  localparam int VOLT_DIV    = 154;
  localparam int VOLT_SAT    = 255;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 17;
  localparam int VOLT_RECIP  = ((1 << RECIP_SHIFT) + VOLT_DIV - 1) / VOLT_DIV;
  localparam int VPROD_W     = VNUM_W + RECIP_W;
  localparam int VQ_W        = VPROD_W - RECIP_SHIFT;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_RAMP,
    KIND_DIRECT,
    KIND_NOP
  } kind_t;

  // Result of one bit-serial divider lane
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  // Symmetric clamp to +/- limit
  function automatic logic signed [SPD_W-1:0] clamp_speed(
    input logic signed [SPD_W-1:0] s,
    input logic [MAXS_W-1:0]       m
  );
    logic signed [SPD_W:0] lim;
    logic signed [SPD_W:0] sx;
    logic signed [SPD_W:0] res;
    lim = $signed({2'b00, m});
    sx  = $signed({s[SPD_W-1], s});
    if (sx < -lim) begin
      res = -lim;
    end else if (sx > lim) begin
      res = lim;
    end else begin
      res = sx;
    end
    return res[SPD_W-1:0];
  endfunction

endpackage

### hdl/motor_speed_slew_ramp_top.sv
// Three-motor speed slew-rate limiter: top level with sequencer and ramp state.
// Depends on msr_pkg, msr_div_lane, msr_volt.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   in_      | in_valid / in_stall | kind, target_a/b/c, motor_index,
//            |                     | direct_speed, raw_voltage
//   out_     | out_valid/out_stall | speed_a/b/c, bus_voltage, ramping,
//            |                     | timeout_fired
//   cfg_     | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
// One item at a time. Direct set and no-op: transfer, FIN, result register. Tick:
// ADV, then ADV2 when a step is taken, then FIN. Ramp command (or a tick that
// hits the timeout) with a nonzero step total: RAMP0, RAMP1 and DIV, where the
// three bit-serial divider lanes run SPD_W + FRAC_BITS = 24 steps in parallel.
// Synchronous active-low reset loads the register defaults and an idle ramp.
// The result register lets the next item transfer in while a result waits
// on out_stall; a finished item waits in FIN only if that register is full.
module motor_speed_slew_ramp_top import msr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_kind,
  input  logic signed [SPD_W-1:0] in_target_a,
  input  logic signed [SPD_W-1:0] in_target_b,
  input  logic signed [SPD_W-1:0] in_target_c,
  input  logic [1:0]              in_motor_index,
  input  logic signed [SPD_W-1:0] in_direct_speed,
  input  logic [RAW_W-1:0]        in_raw_voltage,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SPD_W-1:0] out_speed_a,
  output logic signed [SPD_W-1:0] out_speed_b,
  output logic signed [SPD_W-1:0] out_speed_c,
  output logic [7:0]              out_bus_voltage,
  output logic                    out_ramping,
  output logic                    out_timeout_fired,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAMP0,
    S_RAMP1,
    S_DIV,
    S_ADV,
    S_ADV2,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [MAXS_W-1:0] max_speed_r, max_speed_nxt;
  logic [SLEW_W-1:0] slew_r, slew_nxt;
  logic [TMO_W-1:0]  timeout_r, timeout_nxt;

  // ramp state
  logic signed [SPD_W-1:0] cur_r [3];
  logic signed [SPD_W-1:0] cur_nxt [3];
  logic signed [SPD_W-1:0] fin_r [3];
  logic signed [SPD_W-1:0] fin_nxt [3];
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic signed [INC_W-1:0] inc_r [3];
  logic signed [INC_W-1:0] inc_nxt [3];
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic [TOT_W-1:0]        count_r, count_nxt;
  logic [TMO_W-1:0]        idle_r, idle_nxt;

  // per-item working registers
  kind_t                   kind_r, kind_nxt;
  logic signed [SPD_W-1:0] tgt_r [3];
  logic signed [SPD_W-1:0] tgt_nxt [3];
  logic [SPD_W-1:0]        mag_r [3];
  logic [SPD_W-1:0]        mag_nxt [3];
  logic [2:0]              neg_r, neg_nxt;
  logic                    fired_r, fired_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SPD_W-1:0] out_spd_r [3];
  logic signed [SPD_W-1:0] out_spd_nxt [3];
  logic [7:0]              out_volt_r, out_volt_nxt;
  logic                    out_ramp_r, out_ramp_nxt;
  logic                    out_fired_r, out_fired_nxt;

  // datapath helpers
  logic                    accept;
  logic                    div_start;
  logic                    div_done;
  div_res_t                div_res [3];
  logic [7:0]              volt;
  logic [TMO_W-1:0]        idle_inc;
  logic signed [SPD_W:0]   diff [3];
  logic [SPD_W:0]          diff_abs [3];
  logic [SPD_W-1:0]        mx;
  logic                    same_tgt;
  logic signed [SPD_W-1:0] in_tgt [3];
  logic signed [INC_W-1:0] quot_s [3];
  logic [SPD_W-1:0]        acc_int [3];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign idle_inc  = idle_r + 1'b1;
  assign div_done  = div_res[0].done & div_res[1].done & div_res[2].done;

  assign in_tgt[0] = in_target_a;
  assign in_tgt[1] = in_target_b;
  assign in_tgt[2] = in_target_c;

  // ramp setup arithmetic: differences, magnitudes, largest magnitude
  always_comb begin
    mx       = '0;
    same_tgt = 1'b1;
    for (int i = 0; i < 3; i++) begin
      diff[i]     = $signed({tgt_r[i][SPD_W-1], tgt_r[i]}) -
                    $signed({cur_r[i][SPD_W-1], cur_r[i]});
      diff_abs[i] = diff[i][SPD_W] ? (SPD_W+1)'(-diff[i]) : diff[i];
      if (diff_abs[i][SPD_W-1:0] > mx) begin
        mx = diff_abs[i][SPD_W-1:0];
      end
      if (tgt_r[i] != fin_r[i]) begin
        same_tgt = 1'b0;
      end
      quot_s[i] = $signed({1'b0, div_res[i].quot});
      // accumulator truncated toward zero
      acc_int[i] = acc_r[i][ACC_W-1:FRAC_BITS];
      if (acc_r[i][ACC_W-1] && (acc_r[i][FRAC_BITS-1:0] != '0)) begin
        acc_int[i] = acc_int[i] + 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    max_speed_nxt = max_speed_r;
    slew_nxt      = slew_r;
    timeout_nxt   = timeout_r;
    cur_nxt       = cur_r;
    fin_nxt       = fin_r;
    acc_nxt       = acc_r;
    inc_nxt       = inc_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    idle_nxt      = idle_r;
    kind_nxt      = kind_r;
    tgt_nxt       = tgt_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    fired_nxt     = fired_r;
    out_spd_nxt   = out_spd_r;
    out_volt_nxt  = out_volt_r;
    out_ramp_nxt  = out_ramp_r;
    out_fired_nxt = out_fired_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_SPEED: max_speed_nxt = cfg_data[MAXS_W-1:0];
        REG_SLEW_RATE: slew_nxt      = cfg_data[SLEW_W-1:0];
        REG_TIMEOUT:   timeout_nxt   = cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = kind_t'(in_kind);
          fired_nxt = 1'b0;
          unique case (kind_t'(in_kind))
            KIND_TICK: begin
              if (idle_inc == timeout_r) begin
                // timeout: ramp all motors to zero
                fired_nxt = 1'b1;
                idle_nxt  = '0;
                for (int i = 0; i < 3; i++) tgt_nxt[i] = '0;
                state_nxt = S_RAMP0;
              end else begin
                idle_nxt  = idle_inc;
                state_nxt = S_ADV;
              end
            end
            KIND_RAMP: begin
              idle_nxt = '0;
              for (int i = 0; i < 3; i++) begin
                tgt_nxt[i] = clamp_speed(in_tgt[i], max_speed_r);
              end
              state_nxt = S_RAMP0;
            end
            KIND_DIRECT: begin
              for (int i = 0; i < 3; i++) begin
                if (in_motor_index == 2'(i)) begin
                  cur_nxt[i] = clamp_speed(in_direct_speed, max_speed_r);
                end
              end
              state_nxt = S_FIN;
            end
            KIND_NOP: state_nxt = S_FIN;
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_RAMP0: begin
        if (same_tgt) begin
          state_nxt = (kind_r == KIND_TICK) ? S_ADV : S_FIN;
        end else begin
          total_nxt = TOT_W'({{(TOT_W-SPD_W){1'b0}}, mx} *
                             {{(TOT_W-SLEW_W){1'b0}}, slew_r});
          count_nxt = '0;
          for (int i = 0; i < 3; i++) begin
            fin_nxt[i] = tgt_r[i];
            acc_nxt[i] = $signed({cur_r[i], {FRAC_BITS{1'b0}}});
            mag_nxt[i] = diff_abs[i][SPD_W-1:0];
            neg_nxt[i] = diff[i][SPD_W];
          end
          state_nxt = S_RAMP1;
        end
      end

      S_RAMP1: begin
        if (total_r == '0) begin
          for (int i = 0; i < 3; i++) inc_nxt[i] = '0;
          state_nxt = (kind_r == KIND_TICK) ? S_ADV : S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          for (int i = 0; i < 3; i++) begin
            inc_nxt[i] = neg_r[i] ? -quot_s[i] : quot_s[i];
          end
          state_nxt = (kind_r == KIND_TICK) ? S_ADV : S_FIN;
        end
      end

      S_ADV: begin
        priority if (count_r < total_r) begin
          for (int i = 0; i < 3; i++) begin
            acc_nxt[i] = acc_r[i] +
                         $signed({{(ACC_W-INC_W){inc_r[i][INC_W-1]}}, inc_r[i]});
          end
          count_nxt = count_r + 1'b1;
          state_nxt = S_ADV2;
        end else if (count_r == total_r) begin
          cur_nxt   = fin_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_ADV2: begin
        for (int i = 0; i < 3; i++) cur_nxt[i] = $signed(acc_int[i]);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_spd_nxt   = cur_r;
          out_volt_nxt  = (kind_r == KIND_TICK) ? volt : 8'd0;
          out_ramp_nxt  = (count_r <= total_r);
          out_fired_nxt = fired_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_speed_r <= MAX_SPEED_RST;
      slew_r      <= SLEW_RATE_RST;
      timeout_r   <= TIMEOUT_RST;
      for (int i = 0; i < 3; i++) begin
        cur_r[i] <= '0;
        fin_r[i] <= '0;
        acc_r[i] <= '0;
        inc_r[i] <= '0;
      end
      total_r     <= '0;
      count_r     <= TOT_W'(1);
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_speed_r <= max_speed_nxt;
      slew_r      <= slew_nxt;
      timeout_r   <= timeout_nxt;
      cur_r       <= cur_nxt;
      fin_r       <= fin_nxt;
      acc_r       <= acc_nxt;
      inc_r       <= inc_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    tgt_r       <= tgt_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    fired_r     <= fired_nxt;
    out_spd_r   <= out_spd_nxt;
    out_volt_r  <= out_volt_nxt;
    out_ramp_r  <= out_ramp_nxt;
    out_fired_r <= out_fired_nxt;
  end

  // one divider lane per motor, all started together
  for (genvar g = 0; g < 3; g++) begin : g_div
    msr_div_lane u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (div_start),
      .mag     (mag_r[g]),
      .divisor (total_r),
      .res     (div_res[g])
    );
  end

  // voltage is sampled on every transfer, used only for ticks
  msr_volt u_volt (
    .clk  (clk),
    .load (accept),
    .raw  (in_raw_voltage),
    .volt (volt)
  );

  assign out_valid         = out_valid_r;
  assign out_speed_a       = out_spd_r[0];
  assign out_speed_b       = out_spd_r[1];
  assign out_speed_c       = out_spd_r[2];
  assign out_bus_voltage   = out_volt_r;
  assign out_ramping       = out_ramp_r;
  assign out_timeout_fired = out_fired_r;

endmodule

### hdl/msr_div_lane.sv
// Bit-serial restoring divider: (mag << FRAC_BITS) / divisor, one quotient bit per cycle.
// Depends on msr_pkg.
module msr_div_lane import msr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SPD_W-1:0] mag,
  input  logic [TOT_W-1:0] divisor,
  output div_res_t         res
);

  logic [TOT_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] dq_r, dq_nxt;
  logic [TOT_W-1:0]  dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;

  logic [TOT_W:0] trial;
  logic [TOT_W:0] trial_sub;
  logic           fits;

  assign trial     = {rem_r, dq_r[DIVD_W-1]};
  assign fits      = (trial >= {1'b0, dvs_r});
  assign trial_sub = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      dq_nxt  = {mag, {FRAC_BITS{1'b0}}};
      dvs_nxt = divisor;
      cnt_nxt = DCNT_W'(DIVD_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? trial_sub[TOT_W-1:0] : trial[TOT_W-1:0];
      dq_nxt   = {dq_r[DIVD_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  // quotient never exceeds 2^FRAC_BITS since divisor >= mag
  assign res.done = done_r;
  assign res.quot = dq_r[QUOT_W-1:0];

endmodule

### hdl/msr_volt.sv
// Bus voltage converter: raw ADC byte to tenths of a volt, two register stages.
// Depends on msr_pkg.
module msr_volt import msr_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic [RAW_W-1:0] raw,
  output logic [7:0]       volt
);

  logic [VNUM_W-1:0]  num_r, num_nxt;
  logic               zero_r, zero_nxt;
  logic [7:0]         volt_r, volt_nxt;
  logic [VPROD_W-1:0] prod;
  logic [VQ_W-1:0]    quo;

  always_comb begin
    num_nxt  = num_r;
    zero_nxt = zero_r;
    if (load) begin
      num_nxt  = VNUM_W'(raw) * VNUM_W'(VOLT_SCALE) + VNUM_W'(VOLT_OFFSET);
      zero_nxt = (raw == '0);
    end
  end

  // floor(num / 154) exact over the numerator range
  assign prod = VPROD_W'(num_r) * VPROD_W'(VOLT_RECIP);
  assign quo  = prod[VPROD_W-1:RECIP_SHIFT];

  always_comb begin
    if (zero_r || (quo > VQ_W'(VOLT_SAT))) begin
      volt_nxt = 8'(VOLT_SAT);
    end else begin
      volt_nxt = quo[7:0];
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    zero_r <= zero_nxt;
    volt_r <= volt_nxt;
  end

  assign volt = volt_r;

endmodule
